// ===== design/vwsg_pkg.sv =====
// Shared types and codes for the vertex weld spatial grid unit.
`default_nettype none
package vwsg_pkg;

	localparam logic [2:0] ST_KEPT    = 3'd0;
	localparam logic [2:0] ST_WELDED  = 3'd1;
	localparam logic [2:0] ST_DUP     = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	localparam logic REQ_START    = 1'b0;
	localparam logic REQ_CLASSIFY = 1'b1;

	localparam logic CFG_INV_CELL = 1'b0;
	localparam logic CFG_WELD_SQ  = 1'b1;

	localparam int SEEN_W  = 16;
	localparam int SEEN_SH = 4;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	typedef struct packed {
		logic        req_type;
		logic [15:0] vert_id;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic [15:0] keep_id;
		logic [2:0]  status;
		logic        merged;
	} out_item_t;

	typedef struct packed {
		logic [15:0]      vid;
		logic [2:0][31:0] grid;
		logic [2:0][31:0] pos;
	} kept_entry_t;

	typedef struct packed {
		logic load;
		logic seen_rd;
		logic chk;
		logic scan_rd;
		logic finish;
		logic clr_wr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_start;
		logic dup_now;
		logic scan_more;
		logic pipe_busy;
		logic out_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== design/vwsg_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module vwsg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/vwsg_ctrl.sv =====
// Controller state machine: clear sweep, lookup, scan and finish sequencing.
`default_nettype none
module vwsg_ctrl import vwsg_pkg::*; #(
	parameter int CNT_W = 11,
	parameter int SAW = 12,
	parameter int SEEN_ROWS = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             in_req,
	input  wire logic             out_ready,
	input  wire dp_sts_t          sts,
	output ctrl_cmd_t             cmd,
	output logic      [CNT_W-1:0] scan_idx,
	output logic      [SAW-1:0]   clr_row
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_LOOK = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	localparam logic [SAW-1:0] ROW_LAST = SAW'(SEEN_ROWS - 1);

	logic [2:0] state_q;
	logic [CNT_W-1:0] idx_q;
	logic [SAW-1:0] row_q;
	logic can_fin;

	assign can_fin  = !sts.out_busy || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign scan_idx = idx_q;
	assign clr_row  = row_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLR:  cmd.clr_wr  = 1'b1;
			S_IDLE: cmd.load    = in_valid;
			S_LOOK: cmd.seen_rd = 1'b1;
			S_CHK:  cmd.chk     = 1'b1;
			S_SCAN: cmd.scan_rd = sts.scan_more;
			S_FIN:  cmd.finish  = can_fin;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					row_q <= row_q + 1'b1;
					if (row_q == ROW_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_req == REQ_START) ? S_FIN : S_LOOK;
					end
				end
				S_LOOK: state_q <= S_CHK;
				S_CHK: begin
					idx_q   <= '0;
					state_q <= sts.dup_now ? S_FIN : S_SCAN;
				end
				S_SCAN: begin
					if (sts.scan_more) begin
						idx_q <= idx_q + 1'b1;
					end else if (!sts.pipe_busy) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (can_fin) begin
						row_q   <= '0;
						state_q <= sts.is_start ? S_CLR : S_IDLE;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	a_start_goes_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && in_req == REQ_START) |=> state_q == S_FIN)
		else $error("start request did not go straight to finish");

	a_fin_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!sts.out_busy || out_ready))
		else $error("result written over a pending item");

	a_clr_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR && row_q == ROW_LAST) |=> state_q == S_IDLE)
		else $error("clear sweep did not end");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_CLR) |-> !in_ready)
		else $error("input accepted during scan or clear");

endmodule
`default_nettype wire

// ===== design/vwsg_dp.sv =====
// Datapath: config, seen map, kept store, cell compute and scan pipeline.
`default_nettype none
module vwsg_dp import vwsg_pkg::*; #(
	parameter int MAX_KEPT = 1024,
	parameter int VERT_ID_BITS = 16,
	parameter int POS_BITS = 32,
	parameter int KAW = 10,
	parameter int CNT_W = 11,
	parameter int SAW = 12,
	parameter int SEEN_ROWS = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire in_item_t         in_data,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_index,
	input  wire logic [63:0]      cfg_data,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output out_item_t             out_data,
	input  wire ctrl_cmd_t        cmd,
	input  wire logic [CNT_W-1:0] scan_idx,
	input  wire logic [SAW-1:0]   clr_row,
	output dp_sts_t               sts
);

	logic [31:0] inv_q;
	logic [63:0] weld_q;
	logic req_q;
	logic [VERT_ID_BITS-1:0] id_q;
	logic [2:0][31:0] pos_q;
	logic [2:0][31:0] cell_q;
	logic [CNT_W-1:0] count_q;
	logic merge_q, dup_q;
	logic found_q;
	logic [4:0] best_rank_q;
	logic [15:0] best_vid_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [31:0] inv_eff;
	logic [15:0] id16;
	logic [SEEN_W-1:0] seen_rdata, seen_wdata, seen_bit;
	logic [SAW-1:0] seen_addr;
	logic seen_we;
	logic kept_we;
	kept_entry_t kept_wdata, kept_rdata;

	assign inv_eff = (inv_q == '0) ? ONE_Q16 : inv_q;
	assign id16 = 16'(id_q);
	assign seen_addr = cmd.clr_wr ? clr_row : SAW'(id_q >> SEEN_SH);
	assign seen_bit = SEEN_W'(1) << id_q[SEEN_SH-1:0];
	assign seen_we = cmd.clr_wr || (cmd.chk && (seen_rdata & seen_bit) == '0);
	assign seen_wdata = cmd.clr_wr ? '0 : (seen_rdata | seen_bit);

	vwsg_ram #(.WIDTH(SEEN_W), .DEPTH(SEEN_ROWS)) u_seen (
		.clk(clk), .we(seen_we), .waddr(seen_addr), .wdata(seen_wdata),
		.re(cmd.seen_rd), .raddr(seen_addr), .rdata(seen_rdata)
	);

	assign kept_we = cmd.finish && req_q && !dup_q && !found_q &&
		(count_q < CNT_W'(MAX_KEPT));
	assign kept_wdata = '{vid: id16, grid: cell_q, pos: pos_q};

	vwsg_ram #(.WIDTH($bits(kept_entry_t)), .DEPTH(MAX_KEPT)) u_kept (
		.clk(clk), .we(kept_we), .waddr(count_q[KAW-1:0]), .wdata(kept_wdata),
		.re(cmd.scan_rd), .raddr(scan_idx[KAW-1:0]), .rdata(kept_rdata)
	);

	// scan pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic m_s2, m_s3, m_s4, m_s5;
	logic [4:0] r_s2, r_s3, r_s4, r_s5;
	logic [15:0] vid_s2, vid_s3, vid_s4, vid_s5;
	logic [2:0][31:0] ad_s2;
	logic [2:0][63:0] sq_s3;
	logic [63:0] sxy_s4, sz_s4, d2_s5;
	logic [2:0][1:0] off;
	logic [2:0] offok;
	logic [2:0][32:0] dif;
	logic [2:0][31:0] adif;
	logic [64:0] sum_xy, sum_all;
	logic hit;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [31:0] dc;
			dc = kept_rdata.grid[a] - cell_q[a];
			offok[a] = 1'b1;
			if (dc == 32'hFFFF_FFFF) begin
				off[a] = 2'd0;
			end else if (dc == 32'd0) begin
				off[a] = 2'd1;
			end else if (dc == 32'd1) begin
				off[a] = 2'd2;
			end else begin
				off[a] = 2'd0;
				offok[a] = 1'b0;
			end
			dif[a] = {kept_rdata.pos[a][31], kept_rdata.pos[a]} - {pos_q[a][31], pos_q[a]};
			adif[a] = dif[a][32] ? 32'(-dif[a]) : dif[a][31:0];
		end
	end

	assign sum_xy = {1'b0, sq_s3[0]} + {1'b0, sq_s3[1]};
	assign sum_all = {1'b0, sxy_s4} + {1'b0, sz_s4};
	assign hit = v_s5 && m_s5 && (d2_s5 <= weld_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		m_s2 <= &offok;
		r_s2 <= 5'(off[2]) * 5'd9 + 5'(off[1]) * 5'd3 + 5'(off[0]);
		vid_s2 <= kept_rdata.vid;
		ad_s2 <= adif;
		for (int a = 0; a < 3; a++) begin
			sq_s3[a] <= 64'(ad_s2[a]) * 64'(ad_s2[a]);
		end
		m_s3 <= m_s2;
		r_s3 <= r_s2;
		vid_s3 <= vid_s2;
		sxy_s4 <= sum_xy[64] ? '1 : sum_xy[63:0];
		sz_s4 <= sq_s3[2];
		m_s4 <= m_s3;
		r_s4 <= r_s3;
		vid_s4 <= vid_s3;
		d2_s5 <= sum_all[64] ? '1 : sum_all[63:0];
		m_s5 <= m_s4;
		r_s5 <= r_s4;
		vid_s5 <= vid_s4;
	end

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data.req_type;
			id_q <= VERT_ID_BITS'(in_data.vert_id);
			pos_q[0] <= 32'($signed(in_data.pos_x[POS_BITS-1:0]));
			pos_q[1] <= 32'($signed(in_data.pos_y[POS_BITS-1:0]));
			pos_q[2] <= 32'($signed(in_data.pos_z[POS_BITS-1:0]));
		end
		if (cmd.seen_rd) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [64:0] prod;
				prod = $signed(pos_q[a]) * $signed({1'b0, inv_eff});
				cell_q[a] <= prod[63:32];
			end
		end
		if (cmd.load) begin
			dup_q <= 1'b0;
		end else if (cmd.chk) begin
			dup_q <= (seen_rdata & seen_bit) != '0;
		end
		if (cmd.load) begin
			found_q <= 1'b0;
		end else if (hit && (!found_q || r_s5 < best_rank_q)) begin
			found_q <= 1'b1;
			best_rank_q <= r_s5;
			best_vid_q <= vid_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 32'd655360000;
			weld_q <= 64'd49;
			count_q <= '0;
			merge_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_INV_CELL: inv_q <= cfg_data[31:0];
					CFG_WELD_SQ:  weld_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (req_q == REQ_START) begin
					count_q <= '0;
					merge_q <= 1'b0;
				end else if (!dup_q && found_q) begin
					merge_q <= 1'b1;
				end else if (kept_we) begin
					count_q <= count_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (req_q == REQ_START) begin
				out_q <= '{keep_id: 16'd0, status: ST_CLEARED, merged: 1'b0};
			end else if (dup_q) begin
				out_q <= '{keep_id: id16, status: ST_DUP, merged: merge_q};
			end else if (found_q) begin
				out_q <= '{keep_id: best_vid_q, status: ST_WELDED, merged: 1'b1};
			end else if (kept_we) begin
				out_q <= '{keep_id: id16, status: ST_KEPT, merged: merge_q};
			end else begin
				out_q <= '{keep_id: id16, status: ST_FULL, merged: merge_q};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts.is_start  = (req_q == REQ_START);
		sts.dup_now   = (seen_rdata & seen_bit) != '0;
		sts.scan_more = scan_idx < count_q;
		sts.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
		sts.out_busy  = out_valid_q;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEPT))
		else $error("kept count past store size");

	a_seen_wr_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.chk && seen_we) |-> !sts.dup_now)
		else $error("seen row rewritten for a repeated id");

	a_merge_on_weld: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && req_q == REQ_CLASSIFY && !dup_q && found_q) |=> merge_q)
		else $error("weld did not set merge flag");

endmodule
`default_nettype wire

// ===== design/vertex_weld_spatial_grid_unit.sv =====
// Top level of the vertex weld spatial grid unit.
//
// channel | handshake              | payload
// in      | in_valid / in_ready    | in_data   (in_item_t)
// out     | out_valid / out_ready  | out_data  (out_item_t)
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Classify: the seen map is read and the id checked, then the scan reads the
// kept store one entry a cycle through a five-stage distance pipeline.
// A duplicate id skips the scan; a start request goes to finish, then a
// seen-map clear sweep over 2^VERT_ID_BITS / 16 rows (4096 at defaults).
// After reset the same clear sweep runs before the first item is taken.
// A stalled output holds the block in its finish step; cfg is always ready.
`default_nettype none
module vertex_weld_spatial_grid_unit import vwsg_pkg::*; #(
	parameter int MAX_KEPT = 1024,
	parameter int VERT_ID_BITS = 16,
	parameter int POS_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int KAW = $clog2(MAX_KEPT);
	localparam int CNT_W = $clog2(MAX_KEPT + 1);
	localparam int SEEN_ROWS = (1 << VERT_ID_BITS) / SEEN_W;
	localparam int SAW = (SEEN_ROWS > 1) ? $clog2(SEEN_ROWS) : 1;

	ctrl_cmd_t cmd;
	dp_sts_t sts;
	logic [CNT_W-1:0] scan_idx;
	logic [SAW-1:0] clr_row;

	assign cfg_ready = 1'b1;

	vwsg_ctrl #(.CNT_W(CNT_W), .SAW(SAW), .SEEN_ROWS(SEEN_ROWS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_req(in_data.req_type), .out_ready(out_ready), .sts(sts), .cmd(cmd),
		.scan_idx(scan_idx), .clr_row(clr_row)
	);

	vwsg_dp #(
		.MAX_KEPT(MAX_KEPT), .VERT_ID_BITS(VERT_ID_BITS), .POS_BITS(POS_BITS),
		.KAW(KAW), .CNT_W(CNT_W), .SAW(SAW), .SEEN_ROWS(SEEN_ROWS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_ready(out_ready), .out_valid(out_valid), .out_data(out_data),
		.cmd(cmd), .scan_idx(scan_idx), .clr_row(clr_row), .sts(sts)
	);

endmodule
`default_nettype wire
